// ----- hw/rtl/orbp_pkg.sv -----
// Shared types, constants and helpers for the overwriting ring buffer pointer manager.
package orbp_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int WORD_W      = 32;
  localparam int TOTAL_W     = 64;
  localparam int TYPE_W      = 2;

  // Largest ring size that offsets can address.
  localparam logic [WORD_W-1:0] SIZE_CAP = (OFFSET_BITS >= WORD_W) ? {WORD_W{1'b1}} :
                                           WORD_W'((64'd1 << OFFSET_BITS) - 64'd1);

  typedef enum logic [TYPE_W-1:0] {
    REQ_WRITE     = 2'd0,
    REQ_READ_FRONT = 2'd1,
    REQ_READ_END  = 2'd2,
    REQ_DROP      = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [WORD_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [WORD_W-1:0]  region_offset;
    logic [WORD_W-1:0]  region_count;
    logic [WORD_W-1:0]  first_part_count;
    logic [WORD_W-1:0]  fill_level;
    logic [WORD_W-1:0]  oldest_offset;
    logic [TOTAL_W-1:0] total_written;
  } rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0]  start_offset;
    logic [WORD_W-1:0]  held_bytes;
    logic [TOTAL_W-1:0] written_total;
  } ring_state_t;

  // Ring size in use: capped to the offset range, zero treated as one.
  function automatic logic [WORD_W-1:0] ring_size_of(input logic [WORD_W-1:0] value);
    logic [WORD_W-1:0] s;
    s = value;
    if (s > SIZE_CAP) s = SIZE_CAP;
    if (s == '0) s = WORD_W'(1);
    return s;
  endfunction

endpackage

// ----- hw/rtl/orbp_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface orbp_req_if;
  logic                        valid;
  logic                        ready;
  logic [orbp_pkg::TYPE_W-1:0] req_type;
  logic [orbp_pkg::WORD_W-1:0] amount;

  modport source (output valid, output req_type, output amount, input ready);
  modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface orbp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [orbp_pkg::WORD_W-1:0]  region_offset;
  logic [orbp_pkg::WORD_W-1:0]  region_count;
  logic [orbp_pkg::WORD_W-1:0]  first_part_count;
  logic [orbp_pkg::WORD_W-1:0]  fill_level;
  logic [orbp_pkg::WORD_W-1:0]  oldest_offset;
  logic [orbp_pkg::TOTAL_W-1:0] total_written;

  modport source (output valid, output accepted, output region_offset, output region_count,
                  output first_part_count, output fill_level, output oldest_offset,
                  output total_written, input ready);
  modport sink   (input valid, input accepted, input region_offset, input region_count,
                  input first_part_count, input fill_level, input oldest_offset,
                  input total_written, output ready);
endinterface

// ----- hw/rtl/orbp_in_reg.sv -----
// Input register stage: captures one request item and holds it until taken.
module orbp_in_reg (
  input  logic          clk,
  input  logic          rst,
  orbp_req_if.sink      req,
  input  logic          take,
  output logic          item_valid,
  output orbp_pkg::req_t item
);
  import orbp_pkg::*;

  logic load;

  assign req.ready = !item_valid || take;
  assign load      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item.req_type <= req.req_type;
      item.amount   <= req.amount;
    end
  end

endmodule

// ----- hw/rtl/orbp_ring_calc.sv -----
// Single-pass pointer arithmetic: next ring state and result for one request.
module orbp_ring_calc (
  input  orbp_pkg::req_t               item,
  input  orbp_pkg::ring_state_t        cur,
  input  logic [orbp_pkg::WORD_W-1:0]  ring_size,
  output orbp_pkg::ring_state_t        nxt,
  output orbp_pkg::rsp_t               rsp
);
  import orbp_pkg::*;

  // One extra bit: offset plus fill can reach twice the ring size.
  logic [WORD_W:0] sz, st, hd, amt;
  logic [WORD_W:0] sum_sh, end_w, room, wr_first, over, sum_so, wr_start;
  logic [WORD_W:0] till_end, n_front, sum_fn, front_start;
  logic [WORD_W:0] tail_len, n_end, hd_end, sum_end, end_off;
  logic            wr_fits;

  always_comb begin
    sz  = {1'b0, ring_size};
    st  = {1'b0, cur.start_offset};
    hd  = {1'b0, cur.held_bytes};
    amt = {1'b0, item.amount};

    // write: lands at end of data, wraps at most once
    sum_sh   = st + hd;
    end_w    = (sum_sh >= sz) ? sum_sh - sz : sum_sh;
    room     = sz - end_w;
    wr_first = (amt < room) ? amt : room;
    wr_fits  = (hd + amt) <= sz;
    over     = amt - (sz - hd);
    sum_so   = st + over;
    wr_start = (sum_so >= sz) ? sum_so - sz : sum_so;

    // front read: bounded by fill and by the wrap point
    till_end    = (hd < (sz - st)) ? hd : (sz - st);
    n_front     = (till_end < amt) ? till_end : amt;
    sum_fn      = st + n_front;
    front_start = (sum_fn >= sz) ? sum_fn - sz : sum_fn;

    // end read: only the part after the wrap point when data wraps
    tail_len = (sum_sh > sz) ? sum_sh - sz : hd;
    n_end    = (amt < tail_len) ? amt : tail_len;
    hd_end   = hd - n_end;
    sum_end  = st + hd_end;
    end_off  = (sum_end >= sz) ? sum_end - sz : sum_end;
  end

  always_comb begin
    nxt                  = cur;
    rsp.accepted         = 1'b1;
    rsp.region_offset    = '0;
    rsp.region_count     = '0;
    rsp.first_part_count = '0;

    case (req_kind_t'(item.req_type))
      REQ_WRITE: begin
        if (amt <= sz) begin
          rsp.region_offset    = end_w[WORD_W-1:0];
          rsp.region_count     = item.amount;
          rsp.first_part_count = wr_first[WORD_W-1:0];
          if (wr_fits) begin
            nxt.held_bytes = cur.held_bytes + item.amount;
          end else begin
            nxt.start_offset = wr_start[WORD_W-1:0];
            nxt.held_bytes   = ring_size;
          end
          nxt.written_total = cur.written_total + TOTAL_W'(item.amount);
        end else begin
          rsp.accepted = 1'b0;
        end
      end
      REQ_READ_FRONT: begin
        rsp.region_offset    = cur.start_offset;
        rsp.region_count     = n_front[WORD_W-1:0];
        rsp.first_part_count = n_front[WORD_W-1:0];
        nxt.start_offset     = front_start[WORD_W-1:0];
        nxt.held_bytes       = cur.held_bytes - n_front[WORD_W-1:0];
      end
      REQ_READ_END: begin
        rsp.region_offset    = end_off[WORD_W-1:0];
        rsp.region_count     = n_end[WORD_W-1:0];
        rsp.first_part_count = n_end[WORD_W-1:0];
        nxt.held_bytes       = hd_end[WORD_W-1:0];
      end
      REQ_DROP: begin
        rsp.region_offset = cur.start_offset;
        if (amt < hd) begin
          nxt.held_bytes = cur.held_bytes - item.amount;
          if (till_end > amt) begin
            nxt.start_offset = cur.start_offset + item.amount;
          end else begin
            nxt.start_offset = item.amount - till_end[WORD_W-1:0];
          end
          rsp.region_count = item.amount;
        end else begin
          // dropping the whole fill rewinds to offset zero
          nxt.start_offset = '0;
          nxt.held_bytes   = '0;
          rsp.region_count = cur.held_bytes;
        end
        rsp.first_part_count = rsp.region_count;
      end
      default: begin
        rsp.accepted = 1'b1;
      end
    endcase

    rsp.fill_level    = nxt.held_bytes;
    rsp.oldest_offset = nxt.start_offset;
    rsp.total_written = nxt.written_total;
  end

endmodule

// ----- hw/rtl/overwriting_ring_buffer_pointers.sv -----
// Top level of the overwriting ring buffer pointer manager.
//
// Keeps the pointers of a byte ring that overwrites its oldest data when
// full: oldest offset, fill level and a 64-bit total of bytes written. Each
// request item (write, read from front, read from end, drop) yields exactly
// one result item, in order. The block takes one item per cycle sustained
// while the sink keeps ready high. An accepted item is held in the input
// register; from there its result is computed and loaded into the result
// register, where the sink can take it. The state update loop closes in a
// single pass through the pointer arithmetic between the input register
// and the state and result registers. While a result waits for the sink,
// one more item can enter the input register; after that the input stalls
// until the result is taken. Writing the ring size (cfg_we/cfg_wdata)
// empties the ring but keeps the written total; write it only while no
// item is in flight. A size of zero acts as one. There is no clearing
// pass after reset.
module overwriting_ring_buffer_pointers (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [orbp_pkg::WORD_W-1:0] cfg_wdata,
  orbp_req_if.sink                    req,
  orbp_rsp_if.source                  rsp
);
  import orbp_pkg::*;

  logic                 item_valid;
  req_t                 item;
  logic                 take;
  ring_state_t          state;
  ring_state_t          state_next;
  rsp_t                 result;
  logic [WORD_W-1:0]    ring_size;

  // Move the held item into the result register once that register frees up.
  assign take = item_valid && (!rsp.valid || rsp.ready);

  orbp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  orbp_ring_calc u_ring_calc (
    .item      (item),
    .cur       (state),
    .ring_size (ring_size),
    .nxt       (state_next),
    .rsp       (result)
  );

  // Pointer state and the effective ring size; a size write empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size           <= ring_size_of({WORD_W{1'b1}});
      state.start_offset  <= '0;
      state.held_bytes    <= '0;
      state.written_total <= '0;
    end else if (cfg_we) begin
      ring_size          <= ring_size_of(cfg_wdata);
      state.start_offset <= '0;
      state.held_bytes   <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  // Result register: hold until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.accepted         <= result.accepted;
      rsp.region_offset    <= result.region_offset;
      rsp.region_count     <= result.region_count;
      rsp.first_part_count <= result.first_part_count;
      rsp.fill_level       <= result.fill_level;
      rsp.oldest_offset    <= result.oldest_offset;
      rsp.total_written    <= result.total_written;
    end
  end

  // Fill never exceeds the ring.
  assert property (@(posedge clk) disable iff (rst) state.held_bytes <= ring_size)
    else $error("fill level above ring size");

  // Oldest offset always lies inside the ring.
  assert property (@(posedge clk) disable iff (rst) state.start_offset < ring_size)
    else $error("oldest offset outside ring");

  // A rejected write leaves the pointers untouched.
  assert property (@(posedge clk) disable iff (rst)
    (take && !result.accepted && !cfg_we) |=> $stable(state))
    else $error("rejected write changed state");

  // Every item taken from the input register shows up as a result.
  assert property (@(posedge clk) disable iff (rst) take |=> rsp.valid)
    else $error("result register not loaded");

  // Reported fill and offset match the state they were computed into.
  assert property (@(posedge clk) disable iff (rst)
    (take && !cfg_we) |=> (rsp.fill_level == state.held_bytes &&
                           rsp.oldest_offset == state.start_offset))
    else $error("result pointers disagree with state");

endmodule
